// File: hw/rtl/pcfg_pkg.sv
// ----------------------------------------------------------------------------
// PCI type-0 configuration header package
// Shared types, access codes, per-word access rules and reset values for
// the emulated 64-byte configuration header.
// ----------------------------------------------------------------------------
package pcfg_pkg;

  // Size of the emulated header in bytes and the number of words it spans.
  localparam int HEADER_BYTES = 64;
  localparam int NUM_WORDS    = HEADER_BYTES / 4;
  // Words that have an entry in the rule table; all others have no bits.
  localparam int TABLE_WORDS  = 16;
  localparam int WIDX_W       = $clog2(TABLE_WORDS);

  // Access kinds.
  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // Valid access sizes in bytes.
  localparam logic [2:0] SizeByte = 3'd1;
  localparam logic [2:0] SizeHalf = 3'd2;
  localparam logic [2:0] SizeWord = 3'd4;

  // Request beat.
  typedef struct packed {
    logic        action;
    logic [15:0] bdf;
    logic [7:0]  offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
  } pcfg_req_t;

  // Result beat.
  typedef struct packed {
    logic        claimed;
    logic        status;
    logic [31:0] read_data;
  } pcfg_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } pcfg_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } pcfg_state_e;

  // Read-only, read-write and write-1-to-clear masks of one word.
  typedef struct packed {
    logic [31:0] ro;
    logic [31:0] rw;
    logic [31:0] w1c;
  } pcfg_rule_t;

  // Access rules of each header word.
  function automatic pcfg_rule_t rule_of(logic [WIDX_W-1:0] idx);
    pcfg_rule_t r;
    r = '{ro: 32'h0, rw: 32'h0, w1c: 32'h0};
    unique case (idx)
      4'd0:    r.ro = 32'hffff_ffff;               // Vendor and device ids
      4'd1: begin                                  // Command and status
        r.ro  = 32'h06b0_02b8;
        r.rw  = 32'h0000_0147;
        r.w1c = 32'hf900_0000;
      end
      4'd2:    r.ro = 32'hffff_ffff;               // Class and revision
      4'd3:    r.ro = 32'hffff_ffff;               // Cache line through BIST
      4'd4:    r.rw = 32'hffff_ff01;               // Base address 0
      4'd11:   r.ro = 32'hffff_ffff;               // Subsystem ids
      4'd13:   r.ro = 32'h0000_00ff;               // Capabilities pointer
      4'd15: begin                                 // Interrupt line and pin
        r.ro  = 32'h0000_ff00;
        r.rw  = 32'h0000_00ff;
        r.w1c = 32'h0400_0000;
      end
      default: r = '{ro: 32'h0, rw: 32'h0, w1c: 32'h0};
    endcase
    return r;
  endfunction

  // Contents of each header word after reset.
  function automatic logic [31:0] word_reset(logic [WIDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      4'd0:    v = 32'h8139_10ec;
      4'd1:    v = 32'h0010_0000;
      4'd2:    v = 32'h0200_0000;
      4'd3:    v = 32'h0000_0010;
      4'd11:   v = 32'h1100_1af4;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/pci_type0_config_space_core.sv
// ----------------------------------------------------------------------------
// PCI type-0 configuration header emulation
// A request is captured at the accepting edge, executed in the execute state,
// and its result beat is registered and shown in the respond state.
// Busy covers execute and result, so a new access is taken only in idle,
// after the controller's capture, execute and respond sequence is done.
// Reset restores the header ids, class, status and cache line, device 0.
// Result beats cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module pci_type0_config_space_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pcfg_pkg::pcfg_req_t  req_i,
  output logic                 result_valid_o,
  output pcfg_pkg::pcfg_rsp_t  rsp_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  pcfg_pkg::pcfg_cmd_t cmd;

  // Access sequencer.
  pcfg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  // Header storage and access logic.
  pcfg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule

// File: hw/rtl/pcfg_ctrl.sv
// ----------------------------------------------------------------------------
// PCI configuration header controller
// Sequences one access at a time: capture, execute, then present the result.
// ----------------------------------------------------------------------------
module pcfg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 result_valid_o,
  output pcfg_pkg::pcfg_cmd_t  cmd_o
);

  pcfg_pkg::pcfg_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcfg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcfg_pkg::StIdle: begin
        if (start) begin
          state_d = pcfg_pkg::StExec;
        end
      end
      pcfg_pkg::StExec: state_d = pcfg_pkg::StResp;
      pcfg_pkg::StResp: state_d = pcfg_pkg::StIdle;
      default:          state_d = pcfg_pkg::StIdle;
    endcase
  end

  // Output logic.
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    cmd_o          = '{capture: 1'b0, execute: 1'b0};
    unique case (state_q)
      pcfg_pkg::StIdle: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      pcfg_pkg::StExec: cmd_o.execute  = 1'b1;
      pcfg_pkg::StResp: result_valid_o = 1'b1;
      default:          busy           = 1'b1;
    endcase
  end

  // An accepted request is executed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute)
    else $error("Captured request was not executed next cycle");

  // Every execution yields exactly one result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> result_valid_o && !cmd_o.execute)
    else $error("Execution did not produce a single result beat");

  // No new request is taken while a result beat is on the ports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy && !cmd_o.capture)
    else $error("Request accepted during a result beat");

endmodule

// File: hw/rtl/pcfg_datapath.sv
// ----------------------------------------------------------------------------
// PCI configuration header datapath
// Holds the header words and the device number, and performs the masked
// read or read-modify-write of one access.
// ----------------------------------------------------------------------------
module pcfg_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcfg_pkg::pcfg_cmd_t  cmd_i,
  input  pcfg_pkg::pcfg_req_t  req_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  output pcfg_pkg::pcfg_rsp_t  rsp_o
);

  localparam int IdxW = 6;

  pcfg_pkg::pcfg_req_t  req_q;
  pcfg_pkg::pcfg_rsp_t  rsp_q, rsp_d;
  logic [15:0]          device_bdf_q;
  logic [31:0]          words_q [pcfg_pkg::TABLE_WORDS];

  logic [IdxW-1:0]             idx;
  logic [pcfg_pkg::WIDX_W-1:0] widx;
  logic                        in_hdr;
  logic                        in_tab;
  logic                        hit;
  logic                        size_ok;
  logic [4:0]                  shift;
  pcfg_pkg::pcfg_rule_t        rule;
  logic [31:0]                 vis;
  logic [31:0]                 shifted;
  logic [31:0]                 mask;
  logic [31:0]                 data;
  logic [31:0]                 new_word;
  logic                        word_we;

  // Decode the captured access.
  assign idx     = req_q.offset[7:2];
  assign widx    = idx[pcfg_pkg::WIDX_W-1:0];
  assign in_tab  = (idx[IdxW-1:pcfg_pkg::WIDX_W] == '0);
  assign in_hdr  = ({1'b0, idx} < 7'(pcfg_pkg::NUM_WORDS));
  assign hit     = (req_q.bdf == device_bdf_q);
  assign shift   = {req_q.offset[1:0], 3'b000};
  assign rule    = pcfg_pkg::rule_of(widx);
  assign vis     = in_tab ? (words_q[widx] & (rule.ro | rule.rw | rule.w1c)) : 32'h0;
  assign shifted = vis >> shift;
  assign data    = req_q.write_data << shift;

  // Byte-lane mask of a write and size check.
  always_comb begin
    mask    = 32'h0;
    size_ok = 1'b1;
    unique case (req_q.access_size)
      pcfg_pkg::SizeByte: mask = 32'h0000_00ff << shift;
      pcfg_pkg::SizeHalf: mask = 32'h0000_ffff << shift;
      pcfg_pkg::SizeWord: mask = 32'hffff_ffff;
      default:            size_ok = 1'b0;
    endcase
  end

  // Merge the RW bits and clear the W1C bits written as one.
  assign new_word = ((vis & (~mask | ~rule.rw)) | (data & rule.rw & mask))
                    & ~(data & rule.w1c & mask);
  assign word_we  = cmd_i.execute && hit && (req_q.action == pcfg_pkg::ActWrite)
                    && size_ok && in_hdr && in_tab;

  // Result of the access.
  always_comb begin
    rsp_d = '{claimed: 1'b0, status: 1'b0, read_data: 32'h0};
    if (hit) begin
      rsp_d.claimed = 1'b1;
      if (req_q.action == pcfg_pkg::ActWrite) begin
        rsp_d.status = !size_ok;
      end else if (in_hdr) begin
        unique case (req_q.access_size)
          pcfg_pkg::SizeByte: rsp_d.read_data = {24'h0, shifted[7:0]};
          pcfg_pkg::SizeHalf: rsp_d.read_data = {16'h0, shifted[15:0]};
          pcfg_pkg::SizeWord: rsp_d.read_data = vis;
          default:            rsp_d.status    = 1'b1;
        endcase
      end
    end
  end

  // Header words and device number.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_bdf_q <= 16'h0;
      for (int i = 0; i < pcfg_pkg::TABLE_WORDS; i++) begin
        words_q[i] <= pcfg_pkg::word_reset(pcfg_pkg::WIDX_W'(i));
      end
    end else begin
      if (cfg_we_i) begin
        device_bdf_q <= cfg_wdata_i;
      end
      if (word_we) begin
        words_q[widx] <= new_word;
      end
    end
  end

  // Request and result holding registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  // An access for another device leaves an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && !hit |=> rsp_q == '0)
    else $error("Unclaimed access produced a nonzero result");

  // A write never returns read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (req_q.action == pcfg_pkg::ActWrite) |=> rsp_q.read_data == 32'h0)
    else $error("Write returned read data");

  // An error status is only reported for a claimed access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |=> !rsp_q.status || rsp_q.claimed)
    else $error("Error status on an unclaimed access");

endmodule

// File: sim/tb_pci_type0_config_space_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the PCI type-0 configuration header core
// Drives configuration reads and writes through the start/busy command port
// and keeps a shadow copy of the header with its per-word RO, RW and W1C bits.
// It predicts every result beat and checks it field by field. The run has a
// directed part and then random accesses under several device ids, with
// random idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb_pci_type0_config_space_core;

  // Shadow header, device id and the queue of result beats still to come.
  class cfg_header_scoreboard;
    logic [31:0]         header_q [pcfg_pkg::NUM_WORDS];
    logic [15:0]         device_id;
    pcfg_pkg::pcfg_rsp_t rsp_q [$];
    int                  mismatches;
    int                  beats_checked;
    int                  n_reads;
    int                  n_writes;
    int                  n_unclaimed;
    int                  n_bad_size;
    int                  n_outside;

    function new();
      for (int i = 0; i < pcfg_pkg::NUM_WORDS; i++) begin
        header_q[i] = 32'h0;
      end
      header_q[0]   = 32'h8139_10ec;
      header_q[1]   = 32'h0010_0000;
      header_q[2]   = 32'h0200_0000;
      header_q[3]   = 32'h0000_0010;
      header_q[11]  = 32'h1100_1af4;
      device_id     = 16'h0;
      mismatches    = 0;
      beats_checked = 0;
      n_reads       = 0;
      n_writes      = 0;
      n_unclaimed   = 0;
      n_bad_size    = 0;
      n_outside     = 0;
    endfunction

    function void set_device(logic [15:0] id);
      device_id = id;
    endfunction

    // Read-only, read-write and write-1-to-clear bits of one header word.
    function void word_masks(int unsigned idx, output logic [31:0] ro,
                             output logic [31:0] rw, output logic [31:0] w1c);
      ro  = 32'h0;
      rw  = 32'h0;
      w1c = 32'h0;
      case (idx)
        0, 2, 3, 11: ro = 32'hffff_ffff;
        1: begin
          ro  = 32'h06b0_02b8;
          rw  = 32'h0000_0147;
          w1c = 32'hf900_0000;
        end
        4:  rw = 32'hffff_ff01;
        13: ro = 32'h0000_00ff;
        15: begin
          ro  = 32'h0000_ff00;
          rw  = 32'h0000_00ff;
          w1c = 32'h0400_0000;
        end
        default: ;
      endcase
    endfunction

    // Work out the result of an accepted access and update the shadow header.
    function void note_access(pcfg_pkg::pcfg_req_t r);
      logic [31:0] ro, rw, w1c, vis, lane_mask, data, nw;
      int unsigned idx, shift;
      pcfg_pkg::pcfg_rsp_t rsp;
      rsp   = '0;
      idx   = 32'(r.offset[7:2]);
      shift = 8 * r.offset[1:0];
      if (r.bdf != device_id) begin
        n_unclaimed++;
        rsp_q.push_back(rsp);
        return;
      end
      rsp.claimed = 1'b1;
      word_masks(idx, ro, rw, w1c);
      vis = 32'h0;
      if (r.offset < pcfg_pkg::HEADER_BYTES) begin
        vis = header_q[idx] & (ro | rw | w1c);
      end else begin
        n_outside++;
      end
      if (r.action == pcfg_pkg::ActRead) begin
        n_reads++;
        // Past the header every size reads zero with success.
        if (r.offset < pcfg_pkg::HEADER_BYTES) begin
          case (r.access_size)
            pcfg_pkg::SizeByte: rsp.read_data = (vis >> shift) & 32'h0000_00ff;
            pcfg_pkg::SizeHalf: rsp.read_data = (vis >> shift) & 32'h0000_ffff;
            pcfg_pkg::SizeWord: rsp.read_data = vis;
            default: begin
              rsp.status = 1'b1;
              n_bad_size++;
            end
          endcase
        end
      end else begin
        n_writes++;
        case (r.access_size)
          pcfg_pkg::SizeWord: lane_mask = 32'hffff_ffff;
          pcfg_pkg::SizeHalf: lane_mask = 32'h0000_ffff << shift;
          pcfg_pkg::SizeByte: lane_mask = 32'h0000_00ff << shift;
          default: begin
            lane_mask  = 32'h0;
            rsp.status = 1'b1;
            n_bad_size++;
          end
        endcase
        // Merge the RW bits under the lanes, clear W1C bits written as one.
        if (!rsp.status && r.offset < pcfg_pkg::HEADER_BYTES) begin
          data = r.write_data << shift;
          nw   = vis & (~lane_mask | ~rw);
          nw   = nw | (data & rw & lane_mask);
          nw   = nw & ~(data & w1c & lane_mask);
          header_q[idx] = nw;
        end
      end
      rsp_q.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on beat %0d, %s: expected %h, got %h",
                   beats_checked, name, want, got);
        end
      end
    endfunction

    // Compare a result beat with the oldest expectation.
    function void check_result(pcfg_pkg::pcfg_rsp_t got);
      pcfg_pkg::pcfg_rsp_t want;
      if (rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result beat with nothing expected: %h", got);
        end
        return;
      end
      want = rsp_q.pop_front();
      beats_checked++;
      compare_field("claimed", 32'(want.claimed), 32'(got.claimed));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 100000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  pcfg_pkg::pcfg_req_t req_i;
  logic                result_valid_o;
  pcfg_pkg::pcfg_rsp_t rsp_o;
  logic                cfg_we_i;
  logic [15:0]         cfg_wdata_i;

  cfg_header_scoreboard sb;
  int unsigned          cycle_count = 0;
  bit                   idle_on;
  int                   ids_used;

  pci_type0_config_space_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watch accepted beats, result beats and register writes at each edge.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni) begin
      if (result_valid_o) sb.check_result(rsp_o);
      if (start && !busy) sb.note_access(req_i);
      if (cfg_we_i) sb.set_device(cfg_wdata_i);
    end
  end

  function automatic pcfg_pkg::pcfg_req_t build_access(logic act, logic [15:0] bdf,
                                                       logic [7:0] offset,
                                                       logic [2:0] size,
                                                       logic [31:0] data);
    pcfg_pkg::pcfg_req_t r;
    r.action      = act;
    r.bdf         = bdf;
    r.offset      = offset;
    r.access_size = size;
    r.write_data  = data;
    return r;
  endfunction

  // Mostly valid sizes, sometimes any of the eight codes.
  function automatic logic [2:0] random_size();
    if ($urandom_range(99) >= 85) return 3'($urandom_range(7));
    case ($urandom_range(2))
      0:       return pcfg_pkg::SizeByte;
      1:       return pcfg_pkg::SizeHalf;
      default: return pcfg_pkg::SizeWord;
    endcase
  endfunction

  // A random access, mostly to this device and inside the header.
  function automatic pcfg_pkg::pcfg_req_t random_access();
    pcfg_pkg::pcfg_req_t r;
    int unsigned         pick;
    r.action = $urandom_range(1) ? pcfg_pkg::ActWrite : pcfg_pkg::ActRead;
    pick = $urandom_range(99);
    if (pick < 80) r.bdf = sb.device_id;
    else if (pick < 90) r.bdf = sb.device_id ^ (16'h1 << $urandom_range(15));
    else r.bdf = 16'($urandom);
    r.offset      = ($urandom_range(99) < 75) ? 8'($urandom_range(63))
                                              : 8'($urandom_range(255));
    r.access_size = random_size();
    pick = $urandom_range(99);
    if (pick < 70) r.write_data = $urandom;
    else if (pick < 85) r.write_data = 32'hffff_ffff;
    else r.write_data = 32'h0;
    return r;
  endfunction

  // Offer one beat, sometimes after a random idle gap, and wait until it is taken.
  task automatic send_access(pcfg_pkg::pcfg_req_t r);
    if (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Stop offering beats and wait until every expected result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.rsp_q.size() != 0);
    @(posedge clk_i);
  endtask

  // Write the device id while the core is idle.
  task automatic program_device(logic [15:0] id);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    ids_used++;
  endtask

  // Random accesses; three picks in ten are a write followed by a read-back.
  task automatic random_phase(int count);
    pcfg_pkg::pcfg_req_t w;
    int                  k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(99) < 30) begin
        w             = random_access();
        w.action      = pcfg_pkg::ActWrite;
        w.bdf         = sb.device_id;
        w.offset      = 8'($urandom_range(63));
        w.access_size = ($urandom_range(1)) ? pcfg_pkg::SizeWord : random_size();
        send_access(w);
        send_access(build_access(pcfg_pkg::ActRead, sb.device_id,
                                 {w.offset[7:2], 2'b00}, pcfg_pkg::SizeWord, $urandom));
        k += 2;
      end else begin
        send_access(random_access());
        k++;
      end
    end
  endtask

  initial begin
    sb          = new();
    ids_used    = 1;
    idle_on     = 1'b1;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed accesses under the reset device id.
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h00, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h04, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h08, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h0c, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h2c, pcfg_pkg::SizeWord, 32'h0));
    // A byte and a half-word from the top lane, and an unaligned word.
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h03, pcfg_pkg::SizeByte, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h03, pcfg_pkg::SizeHalf, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h01, pcfg_pkg::SizeWord, 32'h0));
    // Base address, command, status clear and interrupt line.
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h10, pcfg_pkg::SizeWord,
                             32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h10, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h04, pcfg_pkg::SizeHalf,
                             32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h07, pcfg_pkg::SizeByte,
                             32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h04, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h3c, pcfg_pkg::SizeWord,
                             32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h3c, pcfg_pkg::SizeWord, 32'h0));
    // Unaligned word write shifts the data up by one lane.
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h11, pcfg_pkg::SizeWord,
                             32'ha5a5_5a5a));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h10, pcfg_pkg::SizeWord, 32'h0));
    // Invalid sizes inside and past the header, accesses past it, and the capabilities pointer.
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'h00, 3'd3, 32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h00, 3'd0, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h80, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'hff, 3'd7, 32'h0));
    send_access(build_access(pcfg_pkg::ActWrite, 16'h0000, 8'hfc, pcfg_pkg::SizeWord,
                             32'hffff_ffff));
    send_access(build_access(pcfg_pkg::ActRead, 16'h0000, 8'h34, pcfg_pkg::SizeWord, 32'h0));
    // Accesses to other devices are not claimed.
    send_access(build_access(pcfg_pkg::ActRead, 16'h0001, 8'h00, pcfg_pkg::SizeWord, 32'h0));
    send_access(build_access(pcfg_pkg::ActWrite, 16'h8000, 8'h10, pcfg_pkg::SizeWord, 32'h0));

    program_device(16'hffff);
    random_phase(140);
    // A long stretch with back-to-back beats.
    program_device(16'h0000);
    idle_on = 1'b0;
    random_phase(140);
    idle_on = 1'b1;
    program_device(16'($urandom));
    random_phase(70);
    drain_results();
    random_phase(70);
    program_device(16'h5aa5);
    random_phase(140);
    program_device(16'($urandom));
    random_phase(140);

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d claimed reads and %0d claimed writes under %0d device ids: %0d unclaimed,",
             sb.n_reads, sb.n_writes, ids_used, sb.n_unclaimed);
    $display("%0d with a bad size, %0d past the header; %0d beats checked, %0d mismatches.",
             sb.n_bad_size, sb.n_outside, sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.rsp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
